[rtl/clsd_pkg.sv]
`timescale 1ns / 1ps
package clsd_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] position;
    logic [4:0] entry_count;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic compare;
    logic insert_wr;
    logic delete_go;
  } cell_ctrl_t;

endpackage

[rtl/clsd_cell.sv]
`timescale 1ns / 1ps
module clsd_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  clsd_pkg::cell_ctrl_t ctrl,
  input  logic signed [31:0]  key,
  input  logic                occupied,
  input  logic                tail,
  input  logic                seen_in,
  input  logic signed [31:0]  next_entry,
  output logic                seen_out,
  output logic                first,
  output logic signed [31:0]  entry
);
  import clsd_pkg::*;

  logic signed [31:0] entry_r;
  logic               match_r;

  assign seen_out = seen_in | match_r;
  assign first    = match_r & ~seen_in;
  assign entry    = entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctrl.compare) begin
      match_r <= occupied && (entry_r == key);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert_wr && tail) begin
      entry_r <= key;
    end else if (ctrl.delete_go && seen_out) begin
      entry_r <= next_entry;
    end
  end

endmodule

[rtl/compacting_list_search_delete_unit.sv]
`timescale 1ns / 1ps
// Each item passes through the compare state and the commit state of the cell chain;
// the result is written to the output register on commit. A new item is accepted in
// the commit state of the last one; a stalled output holds both the commit and the input.
// Reset: synchronous, active low; clears the entry count, the handshake state and
// the match bits. Stored entries are not cleared and need no clearing pass.
module compacting_list_search_delete_unit #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  clsd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output clsd_pkg::out_item_t out_data
);
  import clsd_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = (IW > 4) ? IW : 4;
  localparam int EW = (CW > 5) ? CW : 5;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      used_r, used_nxt;
  logic [1:0]         cmd_r;
  logic signed [31:0] key_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               can_commit, commit, accept, found, full;
  cell_ctrl_t         ctrl;
  logic [DEPTH:0]     seen;
  logic [DEPTH-1:0]   first;
  logic signed [31:0] entry_w [DEPTH];
  logic [PW-1:0]      pos_w;
  logic [EW-1:0]      cnt_w;
  logic [1:0]         status_w;

  assign can_commit = !out_valid_r || !out_stall;
  assign accept     = in_valid && !in_stall;
  assign found      = seen[DEPTH];
  assign full       = (used_r == CW'(DEPTH));
  assign seen[0]    = 1'b0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_CMP;
      S_CMP:    state_nxt = S_COMMIT;
      S_COMMIT: if (can_commit) state_nxt = in_valid ? S_CMP : S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = 1'b1;
    commit         = 1'b0;
    ctrl.compare   = 1'b0;
    unique case (state_r)
      S_IDLE:   in_stall = 1'b0;
      S_CMP:    ctrl.compare = 1'b1;
      S_COMMIT: begin
        in_stall = !can_commit;
        commit   = can_commit;
      end
      default:  in_stall = 1'b1;
    endcase
    ctrl.insert_wr = commit && (cmd_r == CMD_INSERT) && !full;
    ctrl.delete_go = commit && (cmd_r == CMD_DELETE) && found;
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [31:0] nxt_e;
      if (g == DEPTH - 1) begin : g_last
        assign nxt_e = entry_w[g];
      end else begin : g_mid
        assign nxt_e = entry_w[g+1];
      end
      clsd_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .key        (key_r),
        .occupied   (CW'(g) < used_r),
        .tail       (CW'(g) == used_r),
        .seen_in    (seen[g]),
        .next_entry (nxt_e),
        .seen_out   (seen[g+1]),
        .first      (first[g]),
        .entry      (entry_w[g])
      );
    end
  endgenerate

  always_comb begin
    pos_w = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pos_w = pos_w | (first[i] ? PW'(i) : PW'(0));
    end
  end

  always_comb begin
    used_nxt = used_r;
    status_w = ST_OK;
    case (cmd_r)
      CMD_INSERT: begin
        if (full) status_w = ST_FULL;
        else      used_nxt = used_r + CW'(1);
      end
      CMD_SEARCH: if (!found) status_w = ST_NOTFOUND;
      CMD_DELETE: begin
        if (!found) status_w = ST_NOTFOUND;
        else        used_nxt = used_r - CW'(1);
      end
      default: status_w = ST_OK;
    endcase
    cnt_w = EW'(used_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        used_r      <= used_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data.cmd;
      key_r <= in_data.value;
    end
    if (commit) begin
      out_data_r.status      <= status_w;
      out_data_r.position    <= (status_w == ST_OK && (cmd_r == CMD_SEARCH ||
                                 cmd_r == CMD_DELETE)) ? pos_w[3:0] : 4'd0;
      out_data_r.entry_count <= cnt_w[4:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_COMMIT)
    else $error("result appeared without a commit cycle");

  a_cmp_then_commit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |=> state_r == S_COMMIT)
    else $error("compare cycle not followed by commit");

  a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_CMP)
    else $error("accepted transfer did not start a compare");

endmodule
